// ----- hdl/gwm_pkg.sv -----
// Shared types and constants for the glob wildcard matcher.
`default_nettype none
package gwm_pkg;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ANY   = 8'h3F;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_NOT   = 8'h5E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_ESC   = 8'h5C;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRAIL_ESC = 3'd1;
	localparam logic [2:0] ST_UNCLOSED  = 3'd2;
	localparam logic [2:0] ST_BAD_RANGE = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [3:0] {
		PS_IDLE,
		PS_START,
		PS_ELEM,
		PS_ESC,
		PS_NEG,
		PS_CLS,
		PS_LO_ESC,
		PS_AFTER_LO,
		PS_HI,
		PS_HI_ESC
	} parse_state_t;

	// element write towards the cell row
	typedef struct packed {
		logic         clr;
		logic         en;
		logic         star;
		logic [255:0] set;
	} elem_wr_t;

	// per-byte control broadcast to every cell
	typedef struct packed {
		logic step;
		logic init;
	} cell_ctl_t;

	function automatic logic [255:0] range_mask(input logic [7:0] a, input logic [7:0] b);
		logic [7:0]   lo;
		logic [7:0]   hi;
		logic [255:0] m;
		lo = (a > b) ? b : a;
		hi = (a > b) ? a : b;
		for (int k = 0; k < 256; k++) begin
			m[k] = (8'(k) >= lo) && (8'(k) <= hi);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/glob_wildcard_matcher.sv -----
// Top level of the glob wildcard matcher: request handshake, cell row, result register.
`default_nettype none
// Whole-string glob matcher. Pattern bytes (mode 0) are written one per cycle,
// unless in_stall holds them off, into a small store. When the pattern ends
// it is parsed into a row of PATTERN_MAX cells, mostly one pattern byte per
// cycle, and one load-status result is returned. After the final pattern
// byte, requests are held off during the parse and then the re-arm of the
// row. Target bytes (mode 1) then go at one per cycle while not stalled.
// Every cell checks the byte against its element in parallel. The live
// positions then move on, with star closure rippling along the row. When a
// target ends, its verdict is returned and the row is re-armed before the
// next request is taken. A target request that arrives while a pattern load
// is still open first triggers a silent parse of what has been loaded.
// Requests are also held off while an undelivered result is stalled. Syntax
// errors and an overlong pattern make every verdict a mismatch.
module glob_wildcard_matcher #(
	parameter int PATTERN_MAX = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       mode,
	input  wire logic [7:0] ch,
	input  wire logic       empty_req,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic            matched,
	output logic [2:0]      status
);
	import gwm_pkg::*;

	localparam int N  = PATTERN_MAX;
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// load bookkeeping
	logic          load_open_q;
	logic [LW-1:0] len_q;
	logic [2:0]    pstat_q;
	logic          silent_q;
	logic          init_pend_q;

	// result register
	logic          out_valid_q, kind_q, matched_q;
	logic [2:0]    status_q;

	logic          acc, fin, fits, silent_go;
	logic [LW-1:0] len_base, len_new;
	logic [2:0]    stat_base, stat_new;

	// parser link
	logic          wr_en, p_start, p_busy, p_done;
	logic [LW-1:0] p_len, p_count;
	logic [2:0]    p_status;
	elem_wr_t      ewr;
	logic [AW-1:0] ewr_idx;

	// cell row
	cell_ctl_t     ctl;
	logic [N:0]    adv, clos, lvq, lnx, lv_sel;

	logic          e_long, e_done, e_tgt, emit;

	assign fin       = last | empty_req;
	// a target may not enter while a pattern load is open: it waits for the silent parse
	assign in_stall  = p_busy | init_pend_q | (out_valid_q & out_stall)
	                 | (in_valid & mode & load_open_q);
	assign acc       = in_valid & ~in_stall;

	assign len_base  = load_open_q ? len_q : '0;
	assign stat_base = load_open_q ? pstat_q : ST_OK;
	assign fits      = (len_base < LW'(PATTERN_MAX));
	assign wr_en     = acc & ~mode & ~empty_req & fits;
	assign len_new   = wr_en ? len_base + 1'b1 : len_base;
	assign stat_new  = (acc & ~mode & ~empty_req & ~fits) ? ST_TOO_LONG : stat_base;

	assign silent_go = in_valid & mode & load_open_q & ~p_busy & ~init_pend_q;
	assign p_start   = (acc & ~mode & fin & (stat_new != ST_TOO_LONG))
	                 | (silent_go & (pstat_q != ST_TOO_LONG));
	assign p_len     = silent_go ? len_q : len_new;

	gwm_parser #(
		.PATTERN_MAX(PATTERN_MAX),
		.LW(LW),
		.AW(AW)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(len_base[AW-1:0]),
		.wr_data(ch),
		.start(p_start),
		.len(p_len),
		.busy(p_busy),
		.done(p_done),
		.status(p_status),
		.count(p_count),
		.ewr(ewr),
		.ewr_idx(ewr_idx)
	);

	// one step per target byte; a re-arm loads the start position plus its star closure
	assign ctl.step = acc & mode & ~empty_req;
	assign ctl.init = init_pend_q;
	assign adv[0]   = ctl.init;
	assign clos[0]  = 1'b0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		gwm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.sel(ewr_idx == AW'(g)),
			.ewr(ewr),
			.ctl(ctl),
			.ch(ch),
			.adv_in(adv[g]),
			.clos_in(clos[g]),
			.adv_out(adv[g+1]),
			.clos_out(clos[g+1]),
			.live_nxt(lnx[g]),
			.live(lvq[g])
		);
	end

	// accepting position past the last cell
	logic live_end_q;
	assign lnx[N] = adv[N] | clos[N];
	assign lvq[N] = live_end_q;

	assign lv_sel = empty_req ? lvq : lnx;

	assign e_long = acc & ~mode & fin & (stat_new == ST_TOO_LONG);
	assign e_done = p_done & ~silent_q;
	assign e_tgt  = acc & mode & fin;
	assign emit   = e_long | e_done | e_tgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_open_q <= 1'b0;
			len_q       <= '0;
			pstat_q     <= ST_OK;
			silent_q    <= 1'b0;
			init_pend_q <= 1'b1;
			live_end_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && !mode) begin
				load_open_q <= ~fin;
				len_q       <= len_new;
				pstat_q     <= stat_new;
			end else if (silent_go) begin
				load_open_q <= 1'b0;
			end
			if (p_done) pstat_q <= p_status;
			if (p_start) silent_q <= silent_go;
			init_pend_q <= p_done | e_tgt;
			if (ctl.step || ctl.init) live_end_q <= lnx[N];
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q    <= e_tgt ? KIND_VERDICT : KIND_LOAD;
			matched_q <= e_tgt & (pstat_q == ST_OK) & lv_sel[p_count];
			status_q  <= e_long ? ST_TOO_LONG : (e_done ? p_status : pstat_q);
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign matched   = matched_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");
	a_tgt_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode) |-> !load_open_q)
		else $error("target byte taken with pattern load open");
	a_rearm_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(init_pend_q || p_busy) |-> in_stall)
		else $error("request taken during parse or re-arm");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		p_done |-> p_busy)
		else $error("parse done outside a parse");
`endif

endmodule
`default_nettype wire

// ----- hdl/gwm_cell.sv -----
// One pattern element cell: character set, star flag and live position bit.
`default_nettype none
module gwm_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sel,
	input  wire gwm_pkg::elem_wr_t ewr,
	input  wire gwm_pkg::cell_ctl_t ctl,
	input  wire logic [7:0]        ch,
	input  wire logic              adv_in,
	input  wire logic              clos_in,
	output logic                   adv_out,
	output logic                   clos_out,
	output logic                   live_nxt,
	output logic                   live
);
	import gwm_pkg::*;

	logic         used_q;
	logic         star_q;
	logic [255:0] set_q;
	logic         live_q;
	logic         stay;

	always_comb begin
		adv_out  = ctl.step & live_q & used_q & ~star_q & set_q[ch];
		stay     = ctl.step & live_q & used_q & star_q;
		live_nxt = stay | adv_in | clos_in;
		clos_out = live_nxt & used_q & star_q;
	end

	assign live = live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			live_q <= 1'b0;
		end else begin
			if (ewr.clr) begin
				used_q <= 1'b0;
			end else if (ewr.en && sel) begin
				used_q <= 1'b1;
			end
			if (ctl.step || ctl.init) begin
				live_q <= live_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ewr.en && sel) begin
			star_q <= ewr.star;
			set_q  <= ewr.set;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gwm_parser.sv -----
// Pattern byte store and sequential parser that fills the cell row.
`default_nettype none
module gwm_parser #(
	parameter int PATTERN_MAX = 32,
	parameter int LW = 6,
	parameter int AW = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              start,
	input  wire logic [LW-1:0]     len,
	output logic                   busy,
	output logic                   done,
	output logic [2:0]             status,
	output logic [LW-1:0]          count,
	output gwm_pkg::elem_wr_t      ewr,
	output logic [AW-1:0]          ewr_idx
);
	import gwm_pkg::*;

	logic [7:0]    mem [PATTERN_MAX];
	parse_state_t  state_q, state_nxt;
	logic [LW-1:0] i_q, i_nxt, len_q, n_q, cnt_q;
	logic [7:0]    rd_q, lo_q, lo_nxt;
	logic [255:0]  wset_q, wset_nxt;
	logic          neg_q, neg_nxt;
	logic          at_end;

	assign at_end = (i_q >= len_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			PS_IDLE:  if (start) state_nxt = PS_START;
			PS_START: state_nxt = PS_ELEM;
			PS_ELEM: begin
				if (at_end) state_nxt = PS_IDLE;
				else if (rd_q == CH_ESC) state_nxt = PS_ESC;
				else if (rd_q == CH_OPEN) state_nxt = PS_NEG;
			end
			PS_ESC:   state_nxt = at_end ? PS_IDLE : PS_ELEM;
			PS_NEG:   state_nxt = PS_CLS;
			PS_CLS: begin
				if (at_end) state_nxt = PS_IDLE;
				else if (rd_q == CH_CLOSE) state_nxt = PS_ELEM;
				else if (rd_q == CH_ESC) state_nxt = PS_LO_ESC;
				else state_nxt = PS_AFTER_LO;
			end
			PS_LO_ESC: state_nxt = at_end ? PS_IDLE : PS_AFTER_LO;
			PS_AFTER_LO: state_nxt = (!at_end && rd_q == CH_DASH) ? PS_HI : PS_CLS;
			PS_HI: begin
				if (at_end || rd_q == CH_CLOSE) state_nxt = PS_IDLE;
				else if (rd_q == CH_ESC) state_nxt = PS_HI_ESC;
				else state_nxt = PS_CLS;
			end
			PS_HI_ESC: state_nxt = at_end ? PS_IDLE : PS_CLS;
			default:   state_nxt = PS_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		i_nxt    = i_q;
		wset_nxt = wset_q;
		neg_nxt  = neg_q;
		lo_nxt   = lo_q;
		ewr      = '0;
		done     = 1'b0;
		status   = ST_OK;
		ewr.clr  = (state_q == PS_START);
		case (state_q)
			PS_IDLE, PS_START: i_nxt = '0;
			PS_ELEM: begin
				if (at_end) begin
					done = 1'b1;
				end else begin
					i_nxt = i_q + 1'b1;
					case (rd_q)
						CH_STAR: begin
							ewr.en   = 1'b1;
							ewr.star = 1'b1;
						end
						CH_ESC: ;
						CH_ANY: begin
							ewr.en  = 1'b1;
							ewr.set = '1;
						end
						CH_OPEN: begin
							wset_nxt = '0;
							neg_nxt  = 1'b0;
						end
						default: begin
							ewr.en  = 1'b1;
							ewr.set = range_mask(rd_q, rd_q);
						end
					endcase
				end
			end
			PS_ESC: begin
				if (at_end) begin
					done   = 1'b1;
					status = ST_TRAIL_ESC;
				end else begin
					ewr.en  = 1'b1;
					ewr.set = range_mask(rd_q, rd_q);
					i_nxt   = i_q + 1'b1;
				end
			end
			PS_NEG: begin
				if (!at_end && rd_q == CH_NOT) begin
					neg_nxt = 1'b1;
					i_nxt   = i_q + 1'b1;
				end
			end
			PS_CLS: begin
				if (at_end) begin
					done   = 1'b1;
					status = ST_UNCLOSED;
				end else begin
					i_nxt = i_q + 1'b1;
					if (rd_q == CH_CLOSE) begin
						ewr.en  = 1'b1;
						ewr.set = neg_q ? ~wset_q : wset_q;
					end else if (rd_q != CH_ESC) begin
						lo_nxt = rd_q;
					end
				end
			end
			PS_LO_ESC: begin
				if (at_end) begin
					done   = 1'b1;
					status = ST_UNCLOSED;
				end else begin
					lo_nxt = rd_q;
					i_nxt  = i_q + 1'b1;
				end
			end
			PS_AFTER_LO: begin
				if (!at_end && rd_q == CH_DASH) begin
					i_nxt = i_q + 1'b1;
				end else begin
					wset_nxt = wset_q | range_mask(lo_q, lo_q);
				end
			end
			PS_HI: begin
				if (at_end) begin
					done   = 1'b1;
					status = ST_UNCLOSED;
				end else if (rd_q == CH_CLOSE) begin
					done   = 1'b1;
					status = ST_BAD_RANGE;
				end else begin
					i_nxt = i_q + 1'b1;
					if (rd_q != CH_ESC) wset_nxt = wset_q | range_mask(lo_q, rd_q);
				end
			end
			PS_HI_ESC: begin
				if (at_end) begin
					done   = 1'b1;
					status = ST_UNCLOSED;
				end else begin
					wset_nxt = wset_q | range_mask(lo_q, rd_q);
					i_nxt    = i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy    = (state_q != PS_IDLE);
	assign count   = cnt_q;
	assign ewr_idx = n_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			i_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			i_q     <= i_nxt;
			if (state_q == PS_START) n_q <= '0;
			else if (ewr.en) n_q <= n_q + 1'b1;
			if (done) cnt_q <= (status == ST_OK) ? n_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q   <= mem[i_nxt[AW-1:0]];
		wset_q <= wset_nxt;
		neg_q  <= neg_nxt;
		lo_q   <= lo_nxt;
		if (state_q == PS_IDLE && start) len_q <= len;
	end

endmodule
`default_nettype wire

// ----- sim/gwm_checker.sv -----
// Channel monitor, glob match predictor and result scoreboard for the glob wildcard matcher.
`default_nettype none
module gwm_checker #(
	parameter int PATTERN_MAX = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       mode,
	input  wire logic [7:0] ch,
	input  wire logic       empty_req,
	input  wire logic       last,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic       kind,
	input  wire logic       matched,
	input  wire logic [2:0] status,
	output int              errors,
	output int              pending,
	output int              verdicts,
	output int              hits
);
	import gwm_pkg::*;

	typedef struct {
		logic       kind;
		logic       matched;
		logic [2:0] status;
	} glob_result_t;

	glob_result_t  exp_results[$];

	logic [7:0]    pat_bytes [PATTERN_MAX];
	int            pat_len;
	logic [2:0]    pat_status;
	int            n_elem;
	logic          elem_is_star [PATTERN_MAX];
	logic [255:0]  elem_class [PATTERN_MAX];
	logic [63:0]   live;
	logic          tgt_open;
	logic          loading;

	assign pending = exp_results.size();

	function automatic logic [255:0] byte_span(input logic [7:0] a, input logic [7:0] b);
		logic [255:0] m;
		m = '0;
		for (int k = 0; k < 256; k++) begin
			if ((k >= a && k <= b) || (k >= b && k <= a))
				m[k] = 1'b1;
		end
		return m;
	endfunction

	// left-to-right parse into element table; first syntax error wins
	function automatic logic [2:0] parse_pattern();
		int         i;
		int         n;
		logic       neg;
		logic [7:0] lo;
		i = 0;
		n = 0;
		while (i < pat_len) begin
			elem_class[n] = '0;
			elem_is_star[n] = 1'b0;
			if (pat_bytes[i] == CH_STAR) begin
				elem_is_star[n] = 1'b1;
				i++;
			end else if (pat_bytes[i] == CH_ESC) begin
				if (i + 1 >= pat_len)
					return ST_TRAIL_ESC;
				elem_class[n] = byte_span(pat_bytes[i+1], pat_bytes[i+1]);
				i += 2;
			end else if (pat_bytes[i] == CH_ANY) begin
				elem_class[n] = '1;
				i++;
			end else if (pat_bytes[i] == CH_OPEN) begin
				neg = 1'b0;
				i++;
				if (i < pat_len && pat_bytes[i] == CH_NOT) begin
					neg = 1'b1;
					i++;
				end
				forever begin
					if (i >= pat_len)
						return ST_UNCLOSED;
					if (pat_bytes[i] == CH_CLOSE) begin
						i++;
						break;
					end
					if (pat_bytes[i] == CH_ESC)
						i++;
					if (i >= pat_len)
						return ST_UNCLOSED;
					lo = pat_bytes[i];
					if (i + 1 < pat_len && pat_bytes[i+1] == CH_DASH) begin
						i += 2;
						if (i >= pat_len)
							return ST_UNCLOSED;
						if (pat_bytes[i] == CH_CLOSE)
							return ST_BAD_RANGE;
						if (pat_bytes[i] == CH_ESC)
							i++;
						if (i >= pat_len)
							return ST_UNCLOSED;
						elem_class[n] |= byte_span(lo, pat_bytes[i]);
						i++;
					end else begin
						elem_class[n] |= byte_span(lo, lo);
						i++;
					end
				end
				if (neg)
					elem_class[n] = ~elem_class[n];
			end else begin
				elem_class[n] = byte_span(pat_bytes[i], pat_bytes[i]);
				i++;
			end
			n++;
		end
		n_elem = n;
		return ST_OK;
	endfunction

	function automatic logic [63:0] star_close(input logic [63:0] v);
		for (int i = 0; i < n_elem; i++) begin
			if (v[i] && elem_is_star[i])
				v[i+1] = 1'b1;
		end
		return v;
	endfunction

	function automatic void close_load();
		loading = 1'b0;
		n_elem = 0;
		if (pat_status != ST_TOO_LONG) begin
			pat_status = parse_pattern();
			if (pat_status != ST_OK)
				n_elem = 0;
		end
		live = star_close(64'd1);
	endfunction

	function automatic void step_byte(input logic [7:0] c);
		logic [63:0] nv;
		nv = '0;
		for (int i = 0; i < n_elem; i++) begin
			if (live[i]) begin
				if (elem_is_star[i])
					nv[i] = 1'b1;
				else if (elem_class[i][c])
					nv[i+1] = 1'b1;
			end
		end
		live = star_close(nv);
	endfunction

	function automatic void predict(input logic m, input logic [7:0] c, input logic e,
			input logic l);
		glob_result_t r;
		logic         fin;
		fin = l | e;
		if (m == 1'b0) begin
			tgt_open = 1'b0;
			if (!loading) begin
				loading = 1'b1;
				pat_len = 0;
				pat_status = ST_OK;
				n_elem = 0;
			end
			if (!e) begin
				if (pat_len < PATTERN_MAX) begin
					pat_bytes[pat_len] = c;
					pat_len++;
				end else
					pat_status = ST_TOO_LONG;
			end
			if (fin) begin
				close_load();
				r.kind = KIND_LOAD;
				r.matched = 1'b0;
				r.status = pat_status;
				exp_results.push_back(r);
			end
		end else begin
			if (loading)
				close_load();
			if (!tgt_open) begin
				tgt_open = 1'b1;
				live = star_close(64'd1);
			end
			if (!e)
				step_byte(c);
			if (fin) begin
				tgt_open = 1'b0;
				r.kind = KIND_VERDICT;
				r.matched = (pat_status == ST_OK) && live[n_elem];
				r.status = pat_status;
				exp_results.push_back(r);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glob_result_t want;
		if (!arst_n) begin
			exp_results.delete();
			pat_len = 0;
			pat_status = ST_OK;
			n_elem = 0;
			live = 64'd1;
			tgt_open = 1'b0;
			loading = 1'b0;
			errors = 0;
			verdicts = 0;
			hits = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (exp_results.size() == 0) begin
					$error("result with nothing expected: kind %0d matched %0d status %0d",
						kind, matched, status);
					errors++;
				end else begin
					want = exp_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, matched);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (want.kind == KIND_VERDICT) begin
						verdicts++;
						if (want.matched)
							hits++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict(mode, ch, empty_req, last);
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench top for the glob wildcard matcher: stimulus, idling, watchdog and verdict.
`default_nettype none
module tb_top;
	import gwm_pkg::*;

	localparam int PATTERN_MAX = 32;
	localparam int N_ITEMS     = 400;
	// longest quiet stretch: long receiver hold-off plus a full parse and slack
	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       mode = 1'b0;
	logic [7:0] ch = 8'h61;
	logic       empty_req = 1'b0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic       matched;
	logic [2:0] status;

	int         errors;
	int         pending;
	int         verdicts;
	int         hits;
	int         n_sent = 0;
	int         n_patterns = 0;
	int         idle_count = 0;
	bit         calm = 1'b0;      // no gaps and no random stalls while set; the long hold-off still stalls
	bit         hold_req = 1'b0;  // asks the receiver for one long hold-off
	bit         hold_done = 1'b0;

	glob_wildcard_matcher #(.PATTERN_MAX(PATTERN_MAX)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.ch        (ch),
		.empty_req (empty_req),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.matched   (matched),
		.status    (status)
	);

	gwm_checker #(.PATTERN_MAX(PATTERN_MAX)) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.ch        (ch),
		.empty_req (empty_req),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.matched   (matched),
		.status    (status),
		.errors    (errors),
		.pending   (pending),
		.verdicts  (verdicts),
		.hits      (hits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one request; returns once it has been accepted
	task automatic put(input logic m, input logic [7:0] c, input logic e, input logic l);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		ch <= c;
		empty_req <= e;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// a whole string; an empty one goes as an empty request, the last flag then random
	task automatic put_str(input logic m, input string s, input bit finish = 1'b1);
		if (s.len() == 0) begin
			put(m, 8'($urandom_range(1, 255)), 1'b1, 1'($urandom_range(0, 1)));
		end else begin
			for (int i = 0; i < s.len(); i++)
				put(m, s[i], 1'b0, finish && (i == s.len() - 1));
		end
		if (m == 1'b0 && finish)
			n_patterns++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic string noise_str(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(8'($urandom_range(1, 255)))};
		return s;
	endfunction

	function automatic string abc(input int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(8'($urandom_range(8'h61, 8'h63)))};
		return s;
	endfunction

	// well-formed pattern with a target built element by element to match it, but for "[]", which matches no byte
	task automatic make_pair(output string pat, output string tgt);
		pat = "";
		tgt = "";
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 9))
				0: begin pat = {pat, "*"};     tgt = {tgt, abc($urandom_range(0, 3))}; end
				1: begin pat = {pat, "?"};     tgt = {tgt, abc(1)}; end
				2: begin pat = {pat, "[a-c]"}; tgt = {tgt, "b"}; end
				3: begin pat = {pat, "[^a]"};  tgt = {tgt, "c"}; end
				4: begin pat = {pat, "\\*"};   tgt = {tgt, "*"}; end
				5: begin pat = {pat, "[c-a]"}; tgt = {tgt, "a"}; end
				6: begin pat = {pat, "[]"};    tgt = {tgt, "a"}; end
				7: begin pat = {pat, "[\\]x]"}; tgt = {tgt, "]"}; end
				default: begin
					string l;
					l = abc(1);
					pat = {pat, l};
					tgt = {tgt, l};
				end
			endcase
		end
	endtask

	// receiver: random stalls, calm stretches, one long hold-off on request
	initial begin
		int len;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				len = $urandom_range(0, 99);
				out_stall <= (len >= 55);
				if (len >= 95)
					repeat ($urandom_range(15, 50)) @(posedge clk);
				else
					repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// no acceptance on either side for too long means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("** glob_wildcard_matcher: FAILED **");
			$finish;
		end
	end

	initial begin
		string pat;
		string tgt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern after reset matches only the empty target
		put_str(1'b1, "");
		put_str(1'b1, "a");
		put_str(1'b0, "a*[^b-d]?\\x");
		put_str(1'b1, "aXYze\\");
		put_str(1'b1, "abz?x");
		put_str(1'b0, "[z-a][\\]]");   // reversed range, escaped close in class
		put_str(1'b1, "q]");
		put_str(1'b0, "ab\\");         // trailing backslash
		put_str(1'b1, "ab");
		put_str(1'b0, "[ab");          // unclosed class
		put_str(1'b0, "[a\\");         // backslash left open inside a class
		put_str(1'b0, "[a-]");         // range ending in the close bracket
		put_str(1'b0, "[^]*");         // empty inverted class
		put_str(1'b1, string'({8'hFF, 8'h01}));
		put_str(1'b0, string'({"*", 8'hFF, "?", 8'h80}));
		put_str(1'b1, string'({8'h7F, 8'hFF, 8'h00 + 8'h01, 8'h80}));
		put_str(1'b0, "");             // empty pattern via empty request
		put_str(1'b0, {abc(20), "*", abc(14)}); // overlong
		put_str(1'b1, "abc");
		// open pattern taken over by a target, then a target cut by a pattern byte
		put_str(1'b0, "a*", 1'b0);
		put_str(1'b1, "abb");
		put_str(1'b1, "ab", 1'b0);
		put_str(1'b0, "*");
		put_str(1'b1, "");

		// sender pause until everything is back
		drain();

		// receiver hold-off while the sender keeps offering
		calm = 1'b1;
		hold_req = 1'b1;
		put_str(1'b0, "?*b");
		while (!hold_done) begin
			make_pair(pat, tgt);
			put_str(1'b1, tgt);
		end
		calm = 1'b0;

		while (n_sent < N_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				calm = ~calm;
			case ($urandom_range(0, 19))
				0: put_str(1'b0, noise_str($urandom_range(1, 8)));
				1: put_str(1'b0, noise_str($urandom_range(30, 36)));
				2: put_str(1'b1, noise_str($urandom_range(1, 6)));
				3: begin
					make_pair(pat, tgt);
					put_str(1'b0, {pat, "["}, 1'($urandom_range(0, 1)));
				end
				4: begin
					make_pair(pat, tgt);
					put_str(1'b0, {pat, "[a-]"});
				end
				5: begin
					make_pair(pat, tgt);
					put_str(1'b1, tgt, 1'b0);
				end
				default: begin
					make_pair(pat, tgt);
					put_str(1'b0, pat);
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 2) == 0)
							put_str(1'b1, abc($urandom_range(0, 6)));
						else
							put_str(1'b1, tgt);
					end
				end
			endcase
		end

		calm = 1'b0;
		drain();
		repeat (60) @(posedge clk);

		$display("covered %0d requests, %0d pattern loads, %0d verdicts of which %0d matched",
			n_sent, n_patterns, verdicts, hits);
		$display("syntax errors, overlong patterns, open loads and cut targets included");
		if (errors == 0 && pending == 0)
			$display("** glob_wildcard_matcher: PASSED **");
		else
			$display("** glob_wildcard_matcher: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
